// File: src/cpu6502_pkg.sv
// ----------------------------------------------------------------------------
// cpu6502_pkg
// Shared types, operation codes, flag positions and a flag helper for the 6502
// execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpu6502_pkg;

   // operation codes
   localparam logic [5:0] OP_ADC  = 6'd0;
   localparam logic [5:0] OP_SBC  = 6'd1;
   localparam logic [5:0] OP_AND  = 6'd2;
   localparam logic [5:0] OP_ORA  = 6'd3;
   localparam logic [5:0] OP_EOR  = 6'd4;
   localparam logic [5:0] OP_CMP  = 6'd5;
   localparam logic [5:0] OP_CPX  = 6'd6;
   localparam logic [5:0] OP_CPY  = 6'd7;
   localparam logic [5:0] OP_BIT  = 6'd8;
   localparam logic [5:0] OP_LDA  = 6'd9;
   localparam logic [5:0] OP_LDX  = 6'd10;
   localparam logic [5:0] OP_LDY  = 6'd11;
   localparam logic [5:0] OP_ASL  = 6'd12;
   localparam logic [5:0] OP_LSR  = 6'd13;
   localparam logic [5:0] OP_ROL  = 6'd14;
   localparam logic [5:0] OP_ROR  = 6'd15;
   localparam logic [5:0] OP_INC  = 6'd16;
   localparam logic [5:0] OP_DEC  = 6'd17;
   localparam logic [5:0] OP_INX  = 6'd18;
   localparam logic [5:0] OP_INY  = 6'd19;
   localparam logic [5:0] OP_DEX  = 6'd20;
   localparam logic [5:0] OP_DEY  = 6'd21;
   localparam logic [5:0] OP_TAX  = 6'd22;
   localparam logic [5:0] OP_TAY  = 6'd23;
   localparam logic [5:0] OP_TXA  = 6'd24;
   localparam logic [5:0] OP_TYA  = 6'd25;
   localparam logic [5:0] OP_TSX  = 6'd26;
   localparam logic [5:0] OP_TXS  = 6'd27;
   localparam logic [5:0] OP_CLC  = 6'd28;
   localparam logic [5:0] OP_SEC  = 6'd29;
   localparam logic [5:0] OP_CLI  = 6'd30;
   localparam logic [5:0] OP_SEI  = 6'd31;
   localparam logic [5:0] OP_CLD  = 6'd32;
   localparam logic [5:0] OP_SED  = 6'd33;
   localparam logic [5:0] OP_CLV  = 6'd34;
   localparam logic [5:0] OP_STA  = 6'd35;
   localparam logic [5:0] OP_STX  = 6'd36;
   localparam logic [5:0] OP_STY  = 6'd37;
   localparam logic [5:0] OP_BCC  = 6'd38;
   localparam logic [5:0] OP_BCS  = 6'd39;
   localparam logic [5:0] OP_BEQ  = 6'd40;
   localparam logic [5:0] OP_BNE  = 6'd41;
   localparam logic [5:0] OP_BMI  = 6'd42;
   localparam logic [5:0] OP_BPL  = 6'd43;
   localparam logic [5:0] OP_BVC  = 6'd44;
   localparam logic [5:0] OP_BVS  = 6'd45;
   localparam logic [5:0] OP_IDLE = 6'd46;

   // status bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   // decimal adjust constants
   localparam logic [5:0] BCD_MAX_DIGIT = 6'd9;
   localparam logic [5:0] BCD_ADJ_ADD   = 6'd6;
   localparam logic [5:0] BCD_ADJ_SUB   = 6'd10;

   typedef struct packed {
      logic [5:0] action;
      logic [7:0] operand;
      logic       to_accumulator;
   } cpu6502_req_type;

   typedef struct packed {
      logic [7:0] result;
      logic       write_back;
      logic [7:0] acc;
      logic [7:0] index_x;
      logic [7:0] index_y;
      logic [7:0] status;
      logic       branch_taken;
   } cpu6502_rsp_type;

   // programmer-visible register set
   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] status;
   } cpu6502_arch_type;

   // update N and Z from a value
   function automatic logic [7:0] set_nz(input logic [7:0] st, input logic [7:0] v);
      logic [7:0] r;
      r = st;
      r[FLAG_Z] = (v == 8'd0);
      r[FLAG_N] = v[7];
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/cpu6502_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu6502_execute_unit
// Execute stage of a 6502: ALU, flags and register file, one operation a clock while the response is not stalled.
// ----------------------------------------------------------------------------
// Each request word carries one operation and its already fetched operand.
// The word lands in an input register, is executed against A, X, Y, S and P
// in one pass of combinational logic and the response word is captured in an
// output register; the register set updates at that same edge, so the next
// operation sees it. Throughput is one word per clock while the response
// is not stalled. A stalled response holds the input register full; a new
// request is taken when the input register is empty or the pipeline can move.
// After reset A, X, Y, S, P and the valid flags read zero.
`default_nettype none

module cpu6502_execute_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire cpu6502_pkg::cpu6502_req_type req_word,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output cpu6502_pkg::cpu6502_rsp_type      rsp_word
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   cpu6502_pkg::cpu6502_req_type  in_word_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   cpu6502_pkg::cpu6502_rsp_type  out_word_ff;
   logic                          advance;
   logic                          commit;
   logic                          req_take;
   cpu6502_pkg::cpu6502_arch_type cur_state;
   cpu6502_pkg::cpu6502_arch_type next_state;
   cpu6502_pkg::cpu6502_rsp_type  exec_rsp;

   // pipeline moves when the output register is free or being drained
   assign advance   = ~out_valid_ff | rsp_ready;
   assign commit    = advance & in_valid_ff;
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (commit) begin
         out_word_ff <= exec_rsp;
      end
   end

   cpu6502_alu u_alu (
      .req        (in_word_ff),
      .cur_state  (cur_state),
      .next_state (next_state),
      .rsp        (exec_rsp)
   );

   cpu6502_state u_state (
      .clock      (clock),
      .reset      (reset),
      .commit     (commit),
      .next_state (next_state),
      .cur_state  (cur_state)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // registers are clear right after reset
   a_reset_state: assert property (@(posedge clock)
      reset |=> (cur_state == '0))
      else $error("register set not cleared by reset");

   // status bits 5 and 4 are never set
   a_status_unused: assert property (@(posedge clock) disable iff (reset)
      cur_state.status[5:4] == 2'b00)
      else $error("unused status bits set");

   // result byte is zero unless it is written back
   a_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.write_back |-> rsp_word.result == 8'd0)
      else $error("result byte without write back");

   // a taken branch never writes memory
   a_branch_no_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.branch_taken |-> !rsp_word.write_back)
      else $error("branch with write back");

   // register set only changes when an operation retires
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(cur_state))
      else $error("register set changed without retire");

   // a full pipeline with a stalled response takes no new request
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline full");

endmodule

`default_nettype wire

// File: src/cpu6502_state.sv
// ----------------------------------------------------------------------------
// cpu6502_state
// Architectural registers A, X, Y, S and P, loaded when an operation retires.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu6502_state (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          commit,
   input  wire cpu6502_pkg::cpu6502_arch_type next_state,
   output cpu6502_pkg::cpu6502_arch_type      cur_state
);

   cpu6502_pkg::cpu6502_arch_type arch_ff;
   cpu6502_pkg::cpu6502_arch_type arch_in;

   // hold unless an operation retires
   always_comb begin
      arch_in = commit ? next_state : arch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff <= '0;
      end else begin
         arch_ff <= arch_in;
      end
   end

   assign cur_state = arch_ff;

endmodule

`default_nettype wire

// File: src/cpu6502_alu.sv
// ----------------------------------------------------------------------------
// cpu6502_alu
// Combinational execute logic: one operation against the current register
// set, giving the next register set and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu6502_alu (
   input  wire cpu6502_pkg::cpu6502_req_type  req,
   input  wire cpu6502_pkg::cpu6502_arch_type cur_state,
   output cpu6502_pkg::cpu6502_arch_type      next_state,
   output cpu6502_pkg::cpu6502_rsp_type       rsp
);

   logic [7:0] a;
   logic [7:0] m;
   logic       cin;
   logic       dec_mode;

   // adder results
   logic [4:0] lo_add;
   logic [5:0] lo_add_adj;
   logic       lo_add_cy;
   logic [4:0] hi_add;
   logic [5:0] hi_add_adj;
   logic [8:0] bin_sum;
   logic [7:0] add_res;
   logic       add_c;
   logic       add_v;

   // subtracter results
   logic [5:0] lo_sub;
   logic [5:0] lo_sub_adj;
   logic       lo_sub_bw;
   logic [5:0] hi_sub;
   logic [5:0] hi_sub_adj;
   logic       hi_sub_bw;
   logic [8:0] bin_diff;
   logic [7:0] sub_res;
   logic       sub_c;
   logic       sub_v;

   assign a        = cur_state.acc;
   assign m        = req.operand;
   assign cin      = cur_state.status[cpu6502_pkg::FLAG_C];
   assign dec_mode = cur_state.status[cpu6502_pkg::FLAG_D];

   // add with carry, binary and decimal
   always_comb begin
      lo_add     = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'b0, cin};
      lo_add_adj = ({1'b0, lo_add} > cpu6502_pkg::BCD_MAX_DIGIT)
                   ? {1'b0, lo_add} + cpu6502_pkg::BCD_ADJ_ADD : {1'b0, lo_add};
      lo_add_cy  = (lo_add_adj[5:4] != 2'b00);
      hi_add     = {1'b0, a[7:4]} + {1'b0, m[7:4]} + {4'b0, lo_add_cy};
      hi_add_adj = ({1'b0, hi_add} > cpu6502_pkg::BCD_MAX_DIGIT)
                   ? {1'b0, hi_add} + cpu6502_pkg::BCD_ADJ_ADD : {1'b0, hi_add};
      bin_sum    = {1'b0, a} + {1'b0, m} + {8'b0, cin};
      if (dec_mode) begin
         add_res = {hi_add_adj[3:0], lo_add_adj[3:0]};
         add_c   = (hi_add_adj[5:4] != 2'b00);
         add_v   = 1'b0;
      end else begin
         add_res = bin_sum[7:0];
         add_c   = bin_sum[8];
         add_v   = ~(a[7] ^ m[7]) & (a[7] ^ bin_sum[7]);
      end
   end

   // subtract with borrow, binary and decimal
   always_comb begin
      lo_sub     = {2'b0, a[3:0]} - {2'b0, m[3:0]} - {5'b0, ~cin};
      lo_sub_bw  = lo_sub[5];
      lo_sub_adj = lo_sub_bw ? lo_sub + cpu6502_pkg::BCD_ADJ_SUB : lo_sub;
      hi_sub     = {2'b0, a[7:4]} - {2'b0, m[7:4]} - {5'b0, lo_sub_bw};
      hi_sub_bw  = hi_sub[5];
      hi_sub_adj = hi_sub_bw ? hi_sub + cpu6502_pkg::BCD_ADJ_SUB : hi_sub;
      bin_diff   = {1'b0, a} - {1'b0, m} - {8'b0, ~cin};
      if (dec_mode) begin
         sub_res = {hi_sub_adj[3:0], lo_sub_adj[3:0]};
         sub_c   = ~hi_sub_bw;
         sub_v   = 1'b0;
      end else begin
         sub_res = bin_diff[7:0];
         sub_c   = ~bin_diff[8];
         sub_v   = (a[7] ^ m[7]) & (a[7] ^ bin_diff[7]);
      end
   end

   // operation decode and register update
   always_comb begin
      logic [7:0] st;
      logic [7:0] wb_val;
      logic       wb;
      logic       taken;
      logic [7:0] shv;
      logic [7:0] shr;
      logic [8:0] cmp_diff;
      logic [7:0] cmp_reg;

      next_state = cur_state;
      st         = cur_state.status;
      wb_val     = 8'd0;
      wb         = 1'b0;
      taken      = 1'b0;
      shv        = req.to_accumulator ? a : m;
      shr        = 8'd0;
      cmp_reg    = (req.action == cpu6502_pkg::OP_CPX) ? cur_state.x :
                   (req.action == cpu6502_pkg::OP_CPY) ? cur_state.y : a;
      cmp_diff   = {1'b0, cmp_reg} - {1'b0, m};

      case (req.action)
         cpu6502_pkg::OP_ADC: begin
            st[cpu6502_pkg::FLAG_C] = add_c;
            st[cpu6502_pkg::FLAG_V] = add_v;
            st = cpu6502_pkg::set_nz(st, add_res);
            next_state.acc = add_res;
         end
         cpu6502_pkg::OP_SBC: begin
            st[cpu6502_pkg::FLAG_C] = sub_c;
            st[cpu6502_pkg::FLAG_V] = sub_v;
            st = cpu6502_pkg::set_nz(st, sub_res);
            next_state.acc = sub_res;
         end
         cpu6502_pkg::OP_AND: begin
            next_state.acc = a & m;
            st = cpu6502_pkg::set_nz(st, a & m);
         end
         cpu6502_pkg::OP_ORA: begin
            next_state.acc = a | m;
            st = cpu6502_pkg::set_nz(st, a | m);
         end
         cpu6502_pkg::OP_EOR: begin
            next_state.acc = a ^ m;
            st = cpu6502_pkg::set_nz(st, a ^ m);
         end
         cpu6502_pkg::OP_CMP, cpu6502_pkg::OP_CPX, cpu6502_pkg::OP_CPY: begin
            st[cpu6502_pkg::FLAG_C] = ~cmp_diff[8];
            st = cpu6502_pkg::set_nz(st, cmp_diff[7:0]);
         end
         cpu6502_pkg::OP_BIT: begin
            st[cpu6502_pkg::FLAG_Z] = ((a & m) == 8'd0);
            st[cpu6502_pkg::FLAG_V] = m[6];
            st[cpu6502_pkg::FLAG_N] = m[7];
         end
         cpu6502_pkg::OP_LDA: begin
            next_state.acc = m;
            st = cpu6502_pkg::set_nz(st, m);
         end
         cpu6502_pkg::OP_LDX: begin
            next_state.x = m;
            st = cpu6502_pkg::set_nz(st, m);
         end
         cpu6502_pkg::OP_LDY: begin
            next_state.y = m;
            st = cpu6502_pkg::set_nz(st, m);
         end
         cpu6502_pkg::OP_ASL, cpu6502_pkg::OP_LSR,
         cpu6502_pkg::OP_ROL, cpu6502_pkg::OP_ROR: begin
            if (req.action == cpu6502_pkg::OP_ASL || req.action == cpu6502_pkg::OP_ROL) begin
               st[cpu6502_pkg::FLAG_C] = shv[7];
               shr = {shv[6:0], (req.action == cpu6502_pkg::OP_ROL) & cin};
            end else begin
               st[cpu6502_pkg::FLAG_C] = shv[0];
               shr = {(req.action == cpu6502_pkg::OP_ROR) & cin, shv[7:1]};
            end
            st = cpu6502_pkg::set_nz(st, shr);
            if (req.to_accumulator) begin
               next_state.acc = shr;
            end else begin
               wb_val = shr;
               wb     = 1'b1;
            end
         end
         cpu6502_pkg::OP_INC: begin
            wb_val = m + 8'd1;
            wb     = 1'b1;
            st     = cpu6502_pkg::set_nz(st, m + 8'd1);
         end
         cpu6502_pkg::OP_DEC: begin
            wb_val = m - 8'd1;
            wb     = 1'b1;
            st     = cpu6502_pkg::set_nz(st, m - 8'd1);
         end
         cpu6502_pkg::OP_INX: begin
            next_state.x = cur_state.x + 8'd1;
            st = cpu6502_pkg::set_nz(st, cur_state.x + 8'd1);
         end
         cpu6502_pkg::OP_INY: begin
            next_state.y = cur_state.y + 8'd1;
            st = cpu6502_pkg::set_nz(st, cur_state.y + 8'd1);
         end
         cpu6502_pkg::OP_DEX: begin
            next_state.x = cur_state.x - 8'd1;
            st = cpu6502_pkg::set_nz(st, cur_state.x - 8'd1);
         end
         cpu6502_pkg::OP_DEY: begin
            next_state.y = cur_state.y - 8'd1;
            st = cpu6502_pkg::set_nz(st, cur_state.y - 8'd1);
         end
         cpu6502_pkg::OP_TAX: begin
            next_state.x = a;
            st = cpu6502_pkg::set_nz(st, a);
         end
         cpu6502_pkg::OP_TAY: begin
            next_state.y = a;
            st = cpu6502_pkg::set_nz(st, a);
         end
         cpu6502_pkg::OP_TXA: begin
            next_state.acc = cur_state.x;
            st = cpu6502_pkg::set_nz(st, cur_state.x);
         end
         cpu6502_pkg::OP_TYA: begin
            next_state.acc = cur_state.y;
            st = cpu6502_pkg::set_nz(st, cur_state.y);
         end
         cpu6502_pkg::OP_TSX: begin
            next_state.x = cur_state.sp;
            st = cpu6502_pkg::set_nz(st, cur_state.sp);
         end
         cpu6502_pkg::OP_TXS: next_state.sp = cur_state.x;
         cpu6502_pkg::OP_CLC: st[cpu6502_pkg::FLAG_C] = 1'b0;
         cpu6502_pkg::OP_SEC: st[cpu6502_pkg::FLAG_C] = 1'b1;
         cpu6502_pkg::OP_CLI: st[cpu6502_pkg::FLAG_I] = 1'b0;
         cpu6502_pkg::OP_SEI: st[cpu6502_pkg::FLAG_I] = 1'b1;
         cpu6502_pkg::OP_CLD: st[cpu6502_pkg::FLAG_D] = 1'b0;
         cpu6502_pkg::OP_SED: st[cpu6502_pkg::FLAG_D] = 1'b1;
         cpu6502_pkg::OP_CLV: st[cpu6502_pkg::FLAG_V] = 1'b0;
         cpu6502_pkg::OP_STA: begin
            wb_val = a;
            wb     = 1'b1;
         end
         cpu6502_pkg::OP_STX: begin
            wb_val = cur_state.x;
            wb     = 1'b1;
         end
         cpu6502_pkg::OP_STY: begin
            wb_val = cur_state.y;
            wb     = 1'b1;
         end
         cpu6502_pkg::OP_BCC: taken = ~st[cpu6502_pkg::FLAG_C];
         cpu6502_pkg::OP_BCS: taken =  st[cpu6502_pkg::FLAG_C];
         cpu6502_pkg::OP_BEQ: taken =  st[cpu6502_pkg::FLAG_Z];
         cpu6502_pkg::OP_BNE: taken = ~st[cpu6502_pkg::FLAG_Z];
         cpu6502_pkg::OP_BMI: taken =  st[cpu6502_pkg::FLAG_N];
         cpu6502_pkg::OP_BPL: taken = ~st[cpu6502_pkg::FLAG_N];
         cpu6502_pkg::OP_BVC: taken = ~st[cpu6502_pkg::FLAG_V];
         cpu6502_pkg::OP_BVS: taken =  st[cpu6502_pkg::FLAG_V];
         cpu6502_pkg::OP_IDLE: taken = 1'b0;
         // unused codes leave everything as it is
         default: taken = 1'b0;
      endcase

      next_state.status = st;

      rsp.result       = wb_val;
      rsp.write_back   = wb;
      rsp.acc          = next_state.acc;
      rsp.index_x      = next_state.x;
      rsp.index_y      = next_state.y;
      rsp.status       = st;
      rsp.branch_taken = taken;
   end

endmodule

`default_nettype wire

// File: test/tb_cpu6502_execute_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cpu6502_execute_unit
// Self-checking bench for the 6502 execute stage. A shadow register set
// tracks A, X, Y, S and P and predicts every response word from the request
// words the unit accepts. Directed cases cover binary and decimal arithmetic
// edges, then all action codes are swept and random traffic follows, with
// random gaps on both channels and one long response stall.
// ----------------------------------------------------------------------------

module tb_cpu6502_execute_unit;

   localparam int HOLD_CYCLES = 150;

   // highest action code, an unused one
   localparam logic [5:0] ACTION_LAST = 6'd63;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   cpu6502_pkg::cpu6502_req_type req_word  = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   cpu6502_pkg::cpu6502_rsp_type rsp_word;

   // shadow register set and predicted response words
   cpu6502_pkg::cpu6502_arch_type model_regs = '0;
   cpu6502_pkg::cpu6502_rsp_type  expected_rsp_q[$];
   int                            mismatch_count = 0;

   // idling controls shared with the test tasks
   logic req_idle_on  = 1'b0;
   logic rsp_idle_on  = 1'b0;
   logic hold_request = 1'b0;

   cpu6502_execute_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb_cpu6502_execute_unit NOT OK");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void apply_nz(input logic [7:0] v);
      model_regs.status[cpu6502_pkg::FLAG_Z] = (v == 8'h00);
      model_regs.status[cpu6502_pkg::FLAG_N] = v[7];
   endfunction

   function automatic void compare_model(input logic [7:0] reg_v, input logic [7:0] m);
      model_regs.status[cpu6502_pkg::FLAG_C] = (reg_v >= m);
      apply_nz(reg_v - m);
   endfunction

   // executes one word on the shadow registers and returns the response
   function automatic cpu6502_pkg::cpu6502_rsp_type execute_model(
      input cpu6502_pkg::cpu6502_req_type w);
      cpu6502_pkg::cpu6502_rsp_type o;
      logic [7:0] a, m, v, r, wb_val;
      logic [8:0] s;
      logic       wb, taken, cin, low_borrow, high_borrow;
      int         lo, hi, d;
      a      = model_regs.acc;
      m      = w.operand;
      cin    = model_regs.status[cpu6502_pkg::FLAG_C];
      wb     = 1'b0;
      wb_val = 8'h00;
      taken  = 1'b0;
      case (w.action)
         cpu6502_pkg::OP_ADC: begin
            if (model_regs.status[cpu6502_pkg::FLAG_D]) begin
               lo = int'(a[3:0]) + int'(m[3:0]) + int'(cin);
               if (lo > 9) lo += 6;
               hi = int'(a[7:4]) + int'(m[7:4]) + ((lo > 15) ? 1 : 0);
               if (hi > 9) hi += 6;
               r = {hi[3:0], lo[3:0]};
               model_regs.status[cpu6502_pkg::FLAG_C] = (hi > 15);
               model_regs.status[cpu6502_pkg::FLAG_V] = 1'b0;
            end else begin
               s = {1'b0, a} + {1'b0, m} + {8'h00, cin};
               r = s[7:0];
               model_regs.status[cpu6502_pkg::FLAG_C] = s[8];
               model_regs.status[cpu6502_pkg::FLAG_V] = ~(a[7] ^ m[7]) & (a[7] ^ r[7]);
            end
            apply_nz(r);
            model_regs.acc = r;
         end
         cpu6502_pkg::OP_SBC: begin
            if (model_regs.status[cpu6502_pkg::FLAG_D]) begin
               // low digit borrow is taken before its +10 adjust
               lo = int'(a[3:0]) - int'(m[3:0]) - int'(!cin);
               low_borrow = (lo < 0);
               if (low_borrow) lo += 10;
               hi = int'(a[7:4]) - int'(m[7:4]) - int'(low_borrow);
               high_borrow = (hi < 0);
               if (high_borrow) hi += 10;
               r = {hi[3:0], lo[3:0]};
               model_regs.status[cpu6502_pkg::FLAG_C] = !high_borrow;
               model_regs.status[cpu6502_pkg::FLAG_V] = 1'b0;
            end else begin
               d = int'(a) - int'(m) - int'(!cin);
               r = d[7:0];
               model_regs.status[cpu6502_pkg::FLAG_C] = (d >= 0);
               model_regs.status[cpu6502_pkg::FLAG_V] = (a[7] ^ m[7]) & (a[7] ^ r[7]);
            end
            apply_nz(r);
            model_regs.acc = r;
         end
         cpu6502_pkg::OP_AND: begin model_regs.acc = a & m; apply_nz(model_regs.acc); end
         cpu6502_pkg::OP_ORA: begin model_regs.acc = a | m; apply_nz(model_regs.acc); end
         cpu6502_pkg::OP_EOR: begin model_regs.acc = a ^ m; apply_nz(model_regs.acc); end
         cpu6502_pkg::OP_CMP: compare_model(a, m);
         cpu6502_pkg::OP_CPX: compare_model(model_regs.x, m);
         cpu6502_pkg::OP_CPY: compare_model(model_regs.y, m);
         cpu6502_pkg::OP_BIT: begin
            model_regs.status[cpu6502_pkg::FLAG_Z] = ((a & m) == 8'h00);
            model_regs.status[cpu6502_pkg::FLAG_V] = m[6];
            model_regs.status[cpu6502_pkg::FLAG_N] = m[7];
         end
         cpu6502_pkg::OP_LDA: begin model_regs.acc = m; apply_nz(m); end
         cpu6502_pkg::OP_LDX: begin model_regs.x = m; apply_nz(m); end
         cpu6502_pkg::OP_LDY: begin model_regs.y = m; apply_nz(m); end
         cpu6502_pkg::OP_ASL, cpu6502_pkg::OP_ROL,
         cpu6502_pkg::OP_LSR, cpu6502_pkg::OP_ROR: begin
            v = w.to_accumulator ? a : m;
            if (w.action == cpu6502_pkg::OP_ASL || w.action == cpu6502_pkg::OP_ROL) begin
               model_regs.status[cpu6502_pkg::FLAG_C] = v[7];
               r = {v[6:0], (w.action == cpu6502_pkg::OP_ROL) ? cin : 1'b0};
            end else begin
               model_regs.status[cpu6502_pkg::FLAG_C] = v[0];
               r = {(w.action == cpu6502_pkg::OP_ROR) ? cin : 1'b0, v[7:1]};
            end
            apply_nz(r);
            if (w.to_accumulator) begin
               model_regs.acc = r;
            end else begin
               wb_val = r;
               wb     = 1'b1;
            end
         end
         cpu6502_pkg::OP_INC: begin wb_val = m + 8'd1; wb = 1'b1; apply_nz(wb_val); end
         cpu6502_pkg::OP_DEC: begin wb_val = m - 8'd1; wb = 1'b1; apply_nz(wb_val); end
         cpu6502_pkg::OP_INX: begin
            model_regs.x = model_regs.x + 8'd1;
            apply_nz(model_regs.x);
         end
         cpu6502_pkg::OP_INY: begin
            model_regs.y = model_regs.y + 8'd1;
            apply_nz(model_regs.y);
         end
         cpu6502_pkg::OP_DEX: begin
            model_regs.x = model_regs.x - 8'd1;
            apply_nz(model_regs.x);
         end
         cpu6502_pkg::OP_DEY: begin
            model_regs.y = model_regs.y - 8'd1;
            apply_nz(model_regs.y);
         end
         cpu6502_pkg::OP_TAX: begin model_regs.x = a; apply_nz(a); end
         cpu6502_pkg::OP_TAY: begin model_regs.y = a; apply_nz(a); end
         cpu6502_pkg::OP_TXA: begin model_regs.acc = model_regs.x; apply_nz(model_regs.x); end
         cpu6502_pkg::OP_TYA: begin model_regs.acc = model_regs.y; apply_nz(model_regs.y); end
         cpu6502_pkg::OP_TSX: begin model_regs.x = model_regs.sp; apply_nz(model_regs.sp); end
         cpu6502_pkg::OP_TXS: model_regs.sp = model_regs.x;
         cpu6502_pkg::OP_CLC: model_regs.status[cpu6502_pkg::FLAG_C] = 1'b0;
         cpu6502_pkg::OP_SEC: model_regs.status[cpu6502_pkg::FLAG_C] = 1'b1;
         cpu6502_pkg::OP_CLI: model_regs.status[cpu6502_pkg::FLAG_I] = 1'b0;
         cpu6502_pkg::OP_SEI: model_regs.status[cpu6502_pkg::FLAG_I] = 1'b1;
         cpu6502_pkg::OP_CLD: model_regs.status[cpu6502_pkg::FLAG_D] = 1'b0;
         cpu6502_pkg::OP_SED: model_regs.status[cpu6502_pkg::FLAG_D] = 1'b1;
         cpu6502_pkg::OP_CLV: model_regs.status[cpu6502_pkg::FLAG_V] = 1'b0;
         cpu6502_pkg::OP_STA: begin wb_val = a; wb = 1'b1; end
         cpu6502_pkg::OP_STX: begin wb_val = model_regs.x; wb = 1'b1; end
         cpu6502_pkg::OP_STY: begin wb_val = model_regs.y; wb = 1'b1; end
         cpu6502_pkg::OP_BCC: taken = !model_regs.status[cpu6502_pkg::FLAG_C];
         cpu6502_pkg::OP_BCS: taken =  model_regs.status[cpu6502_pkg::FLAG_C];
         cpu6502_pkg::OP_BEQ: taken =  model_regs.status[cpu6502_pkg::FLAG_Z];
         cpu6502_pkg::OP_BNE: taken = !model_regs.status[cpu6502_pkg::FLAG_Z];
         cpu6502_pkg::OP_BMI: taken =  model_regs.status[cpu6502_pkg::FLAG_N];
         cpu6502_pkg::OP_BPL: taken = !model_regs.status[cpu6502_pkg::FLAG_N];
         cpu6502_pkg::OP_BVC: taken = !model_regs.status[cpu6502_pkg::FLAG_V];
         cpu6502_pkg::OP_BVS: taken =  model_regs.status[cpu6502_pkg::FLAG_V];
         default: ;
      endcase
      o.result       = wb ? wb_val : 8'h00;
      o.write_back   = wb;
      o.acc          = model_regs.acc;
      o.index_x      = model_regs.x;
      o.index_y      = model_regs.y;
      o.status       = model_regs.status;
      o.branch_taken = taken;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (act_v !== exp_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
      end
   endtask

   // predict on accepted request words, check accepted response words
   always @(posedge clock) begin
      cpu6502_pkg::cpu6502_rsp_type exp_w;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_rsp_q.push_back(execute_model(req_word));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response word %h", rsp_word);
            end else begin
               exp_w = expected_rsp_q.pop_front();
               check_field("result",       exp_w.result,       rsp_word.result);
               check_field("write_back",   exp_w.write_back,   rsp_word.write_back);
               check_field("acc",          exp_w.acc,          rsp_word.acc);
               check_field("index_x",      exp_w.index_x,      rsp_word.index_x);
               check_field("index_y",      exp_w.index_y,      rsp_word.index_y);
               check_field("status",       exp_w.status,       rsp_word.status);
               check_field("branch_taken", exp_w.branch_taken, rsp_word.branch_taken);
            end
         end
      end
   end

   // response side: random gaps, plus a long hold when a test asks for one
   initial begin : rsp_side
      int gap_left;
      int hold_left;
      gap_left  = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_idle_on) gap_left = pick_gap();
         end
      end
   end

   // offer one request word and wait until it is taken
   task automatic send_word(input cpu6502_pkg::cpu6502_req_type w);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_op(input logic [5:0] act, input logic [7:0] opnd,
                          input logic to_acc);
      cpu6502_pkg::cpu6502_req_type w;
      w.action         = act;
      w.operand        = opnd;
      w.to_accumulator = to_acc;
      send_word(w);
   endtask

   // random word: weighted toward arithmetic and mode changes, some BCD operands
   function automatic cpu6502_pkg::cpu6502_req_type random_word();
      cpu6502_pkg::cpu6502_req_type w;
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         w.action = $urandom_range(0, 1) ? cpu6502_pkg::OP_ADC : cpu6502_pkg::OP_SBC;
      end else if (r < 27) begin
         w.action = $urandom_range(0, 1) ? cpu6502_pkg::OP_SED : cpu6502_pkg::OP_CLD;
      end else if (r < 32) begin
         w.action = $urandom_range(0, 1) ? cpu6502_pkg::OP_SEC : cpu6502_pkg::OP_CLC;
      end else if (r < 96) begin
         w.action = 6'($urandom_range(int'(cpu6502_pkg::OP_ADC), int'(cpu6502_pkg::OP_BVS)));
      end else begin
         w.action = 6'($urandom_range(int'(cpu6502_pkg::OP_IDLE) + 1, int'(ACTION_LAST)));
      end
      r = $urandom_range(0, 9);
      if (r < 4) begin
         w.operand = 8'(($urandom_range(0, 9) << 4) | $urandom_range(0, 9));
      end else if (r < 6) begin
         case ($urandom_range(0, 4))
            0: w.operand = 8'h00;
            1: w.operand = 8'hFF;
            2: w.operand = 8'h80;
            3: w.operand = 8'h7F;
            default: w.operand = 8'h01;
         endcase
      end else begin
         w.operand = 8'($urandom_range(0, 255));
      end
      w.to_accumulator = 1'($urandom_range(0, 1));
      return w;
   endfunction

   task automatic send_random(input int count);
      cpu6502_pkg::cpu6502_req_type w;
      int done;
      done = 0;
      while (done < count) begin
         w = random_word();
         send_word(w);
         // unused codes and the idle code do not count
         if (w.action <= cpu6502_pkg::OP_BVS) done++;
      end
   endtask

   // arithmetic edges, decimal borrow order, shifts, wraps and an unused code
   task automatic test_special_cases();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_op(cpu6502_pkg::OP_LDA, 8'h7F, 1'b0);
      send_op(cpu6502_pkg::OP_ADC, 8'h01, 1'b0);   // signed overflow
      send_op(cpu6502_pkg::OP_ADC, 8'hFF, 1'b0);   // carry out
      send_op(cpu6502_pkg::OP_SBC, 8'hFF, 1'b1);
      send_op(cpu6502_pkg::OP_LDA, 8'h00, 1'b0);
      send_op(cpu6502_pkg::OP_SED, 8'h00, 1'b0);
      send_op(cpu6502_pkg::OP_LDA, 8'h99, 1'b0);
      send_op(cpu6502_pkg::OP_ADC, 8'h01, 1'b0);   // decimal wrap to zero
      send_op(cpu6502_pkg::OP_CLC, 8'h00, 1'b0);
      send_op(cpu6502_pkg::OP_SBC, 8'h01, 1'b0);   // low digit borrow plus carry-in borrow
      send_op(cpu6502_pkg::OP_ADC, 8'hFF, 1'b0);   // non-BCD digits
      send_op(cpu6502_pkg::OP_SBC, 8'hFA, 1'b0);
      send_op(cpu6502_pkg::OP_CLD, 8'h00, 1'b0);
      send_op(cpu6502_pkg::OP_CPX, 8'hFF, 1'b0);
      send_op(cpu6502_pkg::OP_BIT, 8'hC0, 1'b0);
      send_op(cpu6502_pkg::OP_ASL, 8'h00, 1'b1);
      send_op(cpu6502_pkg::OP_ROR, 8'h01, 1'b0);
      send_op(cpu6502_pkg::OP_INC, 8'hFF, 1'b1);   // accumulator select ignored
      send_op(cpu6502_pkg::OP_DEC, 8'h00, 1'b0);
      send_op(cpu6502_pkg::OP_LDX, 8'h80, 1'b0);
      send_op(cpu6502_pkg::OP_TXS, 8'h00, 1'b0);
      send_op(cpu6502_pkg::OP_TSX, 8'h00, 1'b0);
      send_op(cpu6502_pkg::OP_BMI, 8'h00, 1'b0);
      send_op(ACTION_LAST, 8'hFF, 1'b1);           // unused code acts as idle
      send_op(cpu6502_pkg::OP_STX, 8'h55, 1'b0);
   endtask

   // every action code, including the unused ones
   task automatic test_every_action();
      int code;
      for (code = 0; code <= int'(ACTION_LAST); code++)
         send_op(6'(code), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_random_steady();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_random(150);
   endtask

   task automatic test_random_gaps();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_random(250);
   endtask

   // long response stall while requests keep coming
   task automatic test_output_backpressure();
      req_idle_on  = 1'b0;
      hold_request = 1'b1;
      send_random(40);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      test_every_action();
      test_random_steady();
      test_random_gaps();
      test_output_backpressure();
      req_valid <= 1'b0;
      // drain, then allow for pipeline latency
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_cpu6502_execute_unit OK");
      end else begin
         $display("tb_cpu6502_execute_unit NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/cpu6502_pkg.sv
src/cpu6502_state.sv
src/cpu6502_alu.sv
src/cpu6502_execute_unit.sv
test/tb_cpu6502_execute_unit.sv
